/* hw/rtl/pvp_pkg.sv */
// ----------------------------------------------------------------------------
// pvp_pkg
// Types and constants for the perspective vertex projection pipeline.
// ----------------------------------------------------------------------------
package pvp_pkg;

    localparam int VERT_W   = 32;                 // Q16.16 coordinate
    localparam int COEF_W   = 16;                 // Q3.12 coefficient
    localparam int ROW_W    = 4 * COEF_W;
    localparam int VP_W     = 14;                 // viewport size
    localparam int PROD_W   = COEF_W + VERT_W;    // one coefficient product
    localparam int CLIP_W   = 49;                 // clip value, 28 fraction bits
    localparam int NUM_W    = CLIP_W + 1;         // signed numerator
    localparam int MAG_W    = CLIP_W;             // numerator magnitude
    localparam int MUL_W    = VP_W + 7;           // size * 128, or 65536
    localparam int PN_W     = MAG_W + MUL_W;      // scaled numerator
    localparam int LO_W     = 25;                 // low half of the split multiply
    localparam int DEN_W    = CLIP_W;             // divisor (positive clip w)
    localparam int QUO_W    = 40;                 // quotient bits kept
    localparam int DIV_LAT  = QUO_W + 5;          // divider pipeline depth
    localparam int SCR_W    = 32;
    localparam int DEPTH_W  = 24;
    localparam int IDX_W    = 3;

    localparam logic signed [CLIP_W-1:0] W_THRESH = CLIP_W'(26843);
    localparam logic [MUL_W-1:0] DEPTH_MUL = MUL_W'(65536);

    typedef enum logic [IDX_W-1:0] {
        REG_ROW_X  = 3'd0,
        REG_ROW_Y  = 3'd1,
        REG_ROW_Z  = 3'd2,
        REG_ROW_W  = 3'd3,
        REG_WIDTH  = 3'd4,
        REG_HEIGHT = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [VERT_W-1:0] vertex_x;
        logic signed [VERT_W-1:0] vertex_y;
        logic signed [VERT_W-1:0] vertex_z;
    } vertex_t;

    typedef struct packed {
        logic signed [SCR_W-1:0]   screen_x;
        logic signed [SCR_W-1:0]   screen_y;
        logic signed [DEPTH_W-1:0] depth;
        logic                      visible;
    } screen_t;

    // rounded quotient as it leaves a divider
    typedef struct packed {
        logic             neg;
        logic             over;
        logic [QUO_W:0]   mag;
    } div_res_t;

endpackage

/* hw/rtl/pvp_div.sv */
// ----------------------------------------------------------------------------
// pvp_div
// Pipelined round(num * mul / den): split multiply, then one restoring
// quotient bit per stage, then round half away from zero.
// ----------------------------------------------------------------------------
module pvp_div (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [pvp_pkg::NUM_W-1:0]  num,
    input  logic [pvp_pkg::MUL_W-1:0]         mul,
    input  logic [pvp_pkg::DEN_W-1:0]         den,
    output pvp_pkg::div_res_t                 res
);
    import pvp_pkg::*;

    // stage A: magnitude
    logic               neg_a_reg;
    logic [MAG_W-1:0]   mag_a_reg;
    logic [DEN_W-1:0]   den_a_reg;

    // stage B: partial products
    logic                     neg_b_reg;
    logic [LO_W+MUL_W-1:0]    plo_reg;
    logic [MAG_W-LO_W+MUL_W-1:0] phi_reg;
    logic [DEN_W-1:0]         den_b_reg;

    // stage C: full scaled numerator
    logic               neg_c_reg;
    logic [PN_W-1:0]    pn_reg;
    logic [DEN_W-1:0]   den_c_reg;

    // quotient stages 0..QUO_W
    logic [DEN_W-1:0]   rem_reg  [QUO_W+1];
    logic [QUO_W-1:0]   quo_reg  [QUO_W+1];
    logic [DEN_W-1:0]   den_reg  [QUO_W+1];
    logic               neg_reg  [QUO_W+1];
    logic               over_reg [QUO_W+1];

    div_res_t           res_reg;
    logic [PN_W-QUO_W-1:0] top_bits;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg <= num[NUM_W-1];
            mag_a_reg <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
            den_a_reg <= den;

            neg_b_reg <= neg_a_reg;
            plo_reg   <= (LO_W+MUL_W)'(mag_a_reg[LO_W-1:0]) * (LO_W+MUL_W)'(mul);
            phi_reg   <= (MAG_W-LO_W+MUL_W)'(mag_a_reg[MAG_W-1:LO_W]) *
                         (MAG_W-LO_W+MUL_W)'(mul);
            den_b_reg <= den_a_reg;

            neg_c_reg <= neg_b_reg;
            pn_reg    <= PN_W'(plo_reg) + (PN_W'(phi_reg) << LO_W);
            den_c_reg <= den_b_reg;
        end
    end

    // bits above the kept quotient: any quotient bit there means overflow
    assign top_bits = pn_reg[PN_W-1:QUO_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DEN_W'(top_bits);
            quo_reg[0]  <= pn_reg[QUO_W-1:0];
            den_reg[0]  <= den_c_reg;
            neg_reg[0]  <= neg_c_reg;
            over_reg[0] <= DEN_W'(top_bits) >= den_c_reg;
        end
    end

    for (genvar s = 1; s <= QUO_W; s++)
    begin : g_step
        logic [DEN_W:0]   shifted;
        logic [DEN_W+1:0] diff;
        logic             ge;

        assign shifted = {rem_reg[s-1], quo_reg[s-1][QUO_W-1]};
        assign diff    = {1'b0, shifted} - (DEN_W+2)'(den_reg[s-1]);
        assign ge      = ~diff[DEN_W+1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= ge ? DEN_W'(diff) : DEN_W'(shifted);
                quo_reg[s]  <= {quo_reg[s-1][QUO_W-2:0], ge};
                den_reg[s]  <= den_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                over_reg[s] <= over_reg[s-1];
            end
        end
    end

    // round: add one when twice the remainder reaches the divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.neg  <= neg_reg[QUO_W];
            res_reg.over <= over_reg[QUO_W];
            res_reg.mag  <= (QUO_W+1)'(quo_reg[QUO_W]) +
                            (QUO_W+1)'({rem_reg[QUO_W], 1'b0} >=
                                       {1'b0, den_reg[QUO_W]});
        end
    end

    assign res = res_reg;

endmodule

/* hw/rtl/perspective_vertex_projection.sv */
// ----------------------------------------------------------------------------
// perspective_vertex_projection
// Projects one vertex per unstalled cycle through a 4x4 matrix and the viewport.
// ----------------------------------------------------------------------------
// Takes one vertex every cycle unless the output stalls, and returns its results in
// order. Three stages form clip x/y/z/w and the divider inputs, then three dividers
// of 45 stages each (split multiply, one quotient bit per stage for 40 bits,
// rounding) form screen x, screen y and depth, then saturation logic feeds the
// output register. A stall while the output is valid holds the whole pipe.
// Registers must be written only while the pipe is empty; the block does not enforce it.
module perspective_vertex_projection (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr,
    input  logic [pvp_pkg::IDX_W-1:0]     cfg_index,
    input  logic [pvp_pkg::ROW_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  pvp_pkg::vertex_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output pvp_pkg::screen_t              out_data
);
    import pvp_pkg::*;

    logic [ROW_W-1:0]  row_reg [4];
    logic [VP_W-1:0]   width_reg;
    logic [VP_W-1:0]   height_reg;

    logic en;

    logic signed [VERT_W-1:0]  vert [3];
    logic signed [PROD_W-1:0]  prod_reg [4][3];
    logic signed [COEF_W-1:0]  cw_reg [4];
    logic signed [CLIP_W-1:0]  clip_reg [4];
    logic signed [NUM_W-1:0]   nx_reg, ny_reg, nz_reg;
    logic [DEN_W-1:0]          den_reg;
    logic                      vis3_reg;
    logic                      v1_reg, v2_reg, v3_reg;

    logic                      vd_reg   [DIV_LAT];
    logic                      visd_reg [DIV_LAT];

    div_res_t                  rx, ry, rz;
    logic                      out_valid_reg;
    screen_t                   out_data_reg;
    screen_t                   out_next;

    logic [MUL_W-1:0]          mul_x, mul_y;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 4; r++)
            begin
                row_reg[r] <= ROW_W'(4096) << (COEF_W * r);
            end
            width_reg  <= VP_W'(640);
            height_reg <= VP_W'(540);
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_ROW_X:  row_reg[0] <= cfg_data;
                REG_ROW_Y:  row_reg[1] <= cfg_data;
                REG_ROW_Z:  row_reg[2] <= cfg_data;
                REG_ROW_W:  row_reg[3] <= cfg_data;
                REG_WIDTH:  width_reg  <= cfg_data[VP_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[VP_W-1:0];
                default:    ;
            endcase
        end
    end

    // advance unless a finished beat waits on the output
    assign en       = ~(out_valid_reg & out_stall);
    assign in_stall = ~en;

    assign vert[0] = in_data.vertex_x;
    assign vert[1] = in_data.vertex_y;
    assign vert[2] = in_data.vertex_z;

    // ---------------- matrix stages ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[r][k] <= PROD_W'($signed(row_reg[r][COEF_W*k +: COEF_W])) *
                                      PROD_W'(vert[k]);
                end
                cw_reg[r] <= $signed(row_reg[r][COEF_W*3 +: COEF_W]);
            end
            for (int r = 0; r < 4; r++)
            begin
                clip_reg[r] <= CLIP_W'(prod_reg[r][0]) + CLIP_W'(prod_reg[r][1]) +
                               CLIP_W'(prod_reg[r][2]) +
                               CLIP_W'($signed({cw_reg[r], 16'b0}));
            end
            nx_reg   <= NUM_W'(clip_reg[0]) + NUM_W'(clip_reg[3]);
            ny_reg   <= NUM_W'(clip_reg[3]) - NUM_W'(clip_reg[1]);
            nz_reg   <= NUM_W'(clip_reg[2]);
            den_reg  <= DEN_W'(clip_reg[3]);
            vis3_reg <= clip_reg[3] > W_THRESH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // ---------------- dividers ----------------
    assign mul_x = {width_reg, 7'b0};
    assign mul_y = {height_reg, 7'b0};

    pvp_div u_div_x (.clk(clk), .en(en), .num(nx_reg), .mul(mul_x),
                     .den(den_reg), .res(rx));
    pvp_div u_div_y (.clk(clk), .en(en), .num(ny_reg), .mul(mul_y),
                     .den(den_reg), .res(ry));
    pvp_div u_div_z (.clk(clk), .en(en), .num(nz_reg), .mul(DEPTH_MUL),
                     .den(den_reg), .res(rz));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vd_reg[0] <= v3_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            visd_reg[0] <= vis3_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                visd_reg[i] <= visd_reg[i-1];
            end
        end
    end

    // ---------------- saturation ----------------
    function automatic logic [QUO_W:0] sat_val(div_res_t d, logic [QUO_W:0] lim_pos);
        logic [QUO_W:0] lim;
        lim = d.neg ? lim_pos + (QUO_W+1)'(1) : lim_pos;
        if (d.over || d.mag > lim)
            return d.neg ? -lim : lim;
        return d.neg ? -d.mag : d.mag;
    endfunction

    always_comb
    begin
        logic [QUO_W:0] sx, sy, sz;
        sx = sat_val(rx, (QUO_W+1)'({1'b0, {(SCR_W-1){1'b1}}}));
        sy = sat_val(ry, (QUO_W+1)'({1'b0, {(SCR_W-1){1'b1}}}));
        sz = sat_val(rz, (QUO_W+1)'({1'b0, {(DEPTH_W-1){1'b1}}}));
        out_next = '0;
        if (visd_reg[DIV_LAT-1])
        begin
            out_next.screen_x = sx[SCR_W-1:0];
            out_next.screen_y = sy[SCR_W-1:0];
            out_next.depth    = sz[DEPTH_W-1:0];
            out_next.visible  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vd_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- assertions ----------------
    a_out_follows_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> out_valid == $past(vd_reg[DIV_LAT-1]))
        else $error("output valid does not follow the last pipe stage");

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.visible) |->
        (out_data.screen_x == '0 && out_data.screen_y == '0 && out_data.depth == '0))
        else $error("hidden vertex carries nonzero fields");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v3_reg) && $stable(vd_reg[0]))
        else $error("pipe advanced while the output was stalled");

endmodule
